// ----- rtl/trial_division_primality_test_defines.svh -----
// assertion macros for the primality tester checker
`ifndef TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH

// same-cycle implication under synchronous reset
`define TDPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous reset
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tdpt_pkg.sv -----
// shared types and constants of the primality tester
package tdpt_pkg;

    localparam int FIRST_DIVISOR   = 5;
    localparam int WHEEL_STEP      = 6;
    localparam int PAIR_GAP        = 2;
    localparam int SMALL_PRIME_MAX = 3;
    localparam int LARGEST_UNIT    = 1;
    localparam int THREE_DIVISOR   = 3;

    typedef enum logic {
        DIV_D,
        DIV_D_PLUS_2
    } t_div_sel;

    typedef struct packed {
        logic     load_n;
        logic     div_start;
        t_div_sel div_sel;
        logic     d_init;
        logic     d_step;
    } t_dp_cmd;

    typedef struct packed {
        logic negative;
        logic le_one;
        logic le_three;
        logic even;
        logic mod3_zero;
        logic div_done;
        logic rem_zero;
        logic d_le_q;
    } t_dp_sts;

endpackage

// ----- rtl/tdpt_if.sv -----
// handshake channels for the value and the result items
interface tdpt_value_if #(
    parameter int VALUE_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface tdpt_result_if ();
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

// ----- rtl/tdpt_div.sv -----
// restoring divider, one quotient bit per cycle
module tdpt_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder,
    output logic         o_done
);
    localparam int CntW = $clog2(W + 1);

    logic [CntW-1:0] r_cnt;
    logic            r_done;
    logic [W-1:0]    r_quo;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_dv;

    logic [W:0]      w_shift;
    logic [W+1:0]    w_diff;

    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CntW'(W);
            r_done <= 1'b0;
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dv   <= i_divisor;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CntW'(1);
            r_done <= (r_cnt == CntW'(1));
            if (!w_diff[W+1]) begin
                r_rem <= w_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;
endmodule

// ----- rtl/tdpt_dp.sv -----
// datapath: value and divisor registers around the shared divider
module tdpt_dp
    import tdpt_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_value,
    input  t_dp_cmd      i_cmd,
    output t_dp_sts      o_sts
);
    function automatic logic [255:0] mod3_zero_table();
        logic [255:0] tbl;
        tbl = '0;
        for (int i = 0; i < 256; i++) begin
            tbl[8'(i)] = ((i % THREE_DIVISOR) == 0);
        end
        return tbl;
    endfunction

    localparam logic [255:0] MOD3_ZERO = mod3_zero_table();

    logic [W-1:0] r_n;
    logic [W-1:0] r_d;
    logic [W-1:0] n_divisor;
    logic [W-1:0] w_quo;
    logic [W-1:0] w_rem;
    logic         w_done;
    logic [63:0]  w_pad;
    logic [32:0]  n_fold;
    logic [32:0]  r_fold;
    logic [17:0]  w_f16;
    logic [10:0]  w_f8;
    logic [7:0]   w_f4;

    // residue mod 3 by folding: 2^32, 2^16, 2^8 and 2^4 are all 1 mod 3
    assign w_pad  = 64'(r_n);
    assign n_fold = {1'b0, w_pad[31:0]} + {1'b0, w_pad[63:32]};
    assign w_f16  = {2'b00, r_fold[15:0]} + {1'b0, r_fold[32:16]};
    assign w_f8   = {3'b000, w_f16[7:0]} + {1'b0, w_f16[17:8]};
    assign w_f4   = {4'h0, w_f8[3:0]} + {1'b0, w_f8[10:4]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_n) begin
            r_n <= i_value;
        end
        r_fold <= n_fold;
        if (i_cmd.d_init) begin
            r_d <= W'(FIRST_DIVISOR);
        end else if (i_cmd.d_step) begin
            r_d <= r_d + W'(WHEEL_STEP);
        end
    end

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_D:        n_divisor = r_d;
            DIV_D_PLUS_2: n_divisor = r_d + W'(PAIR_GAP);
        endcase
    end

    tdpt_div #(
        .W (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_n),
        .i_divisor   (n_divisor),
        .o_quotient  (w_quo),
        .o_remainder (w_rem),
        .o_done      (w_done)
    );

    assign o_sts.negative  = r_n[W-1];
    assign o_sts.le_one    = (r_n <= W'(LARGEST_UNIT));
    assign o_sts.le_three  = (r_n <= W'(SMALL_PRIME_MAX));
    assign o_sts.even      = ~r_n[0];
    assign o_sts.mod3_zero = MOD3_ZERO[w_f4];
    assign o_sts.div_done  = w_done;
    assign o_sts.rem_zero  = (w_rem == '0);
    assign o_sts.d_le_q    = (r_d <= w_quo);
endmodule

// ----- rtl/tdpt_ctrl.sv -----
// controller: sequences the small-value checks and the 6k-1/6k+1 trials
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output logic    o_out_is_prime,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MOD3,
        S_DIVD,
        S_WAITD,
        S_DIVD2,
        S_WAITD2,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_res;
    logic   r_out_valid;
    logic   r_out_is_prime;

    always_comb begin
        o_cmd.load_n    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_start = (r_state == S_DIVD) || (r_state == S_DIVD2);
        o_cmd.div_sel   = DIV_D;
        if (r_state == S_DIVD2) begin
            o_cmd.div_sel = DIV_D_PLUS_2;
        end
        o_cmd.d_init = (r_state == S_MOD3) && !i_sts.mod3_zero;
        o_cmd.d_step = (r_state == S_WAITD2) && i_sts.div_done && !i_sts.rem_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    priority if (i_sts.negative || i_sts.le_one) begin
                        r_res   <= 1'b0;
                        r_state <= S_DONE;
                    end else if (i_sts.le_three) begin
                        r_res   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (i_sts.even) begin
                        r_res   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MOD3;
                    end
                end
                S_MOD3: begin
                    if (i_sts.mod3_zero) begin
                        r_res   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: r_state <= S_WAITD;
                S_WAITD: begin
                    if (i_sts.div_done) begin
                        priority if (!i_sts.d_le_q) begin
                            r_res   <= 1'b1;
                            r_state <= S_DONE;
                        end else if (i_sts.rem_zero) begin
                            r_res   <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIVD2;
                        end
                    end
                end
                S_DIVD2: r_state <= S_WAITD2;
                S_WAITD2: begin
                    if (i_sts.div_done) begin
                        if (i_sts.rem_zero) begin
                            r_res   <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIVD;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_is_prime <= r_res;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_out_is_prime = r_out_is_prime;
endmodule

// ----- rtl/trial_division_primality_test.sv -----
// top level of the trial-division primality tester
//
//   channel   dir   payload                        item
//   i_in      in    value [VALUE_WIDTH-1:0] signed  one integer to test
//   o_out     out   is_prime [0]                    one verdict per integer
//
// negative, 0..3 and even values are decided in S_CHECK, odd multiples of 3 in S_MOD3
// every other value goes through trial divisions in the shared
// bit-serial divider, two per 6k-1/6k+1 pair until d*d exceeds the value
// a prime near 2^31 at 32 bits takes about 7700 pairs
// reset is synchronous and active low; one item is in work at a time
// a waiting result does not stop the next item being accepted

module trial_division_primality_test
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tdpt_value_if.sink    i_in,
    tdpt_result_if.source o_out
);
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_out_valid;
    logic    w_out_is_prime;

    tdpt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (w_in_ready),
        .o_out_valid    (w_out_valid),
        .o_out_is_prime (w_out_is_prime),
        .i_out_ready    (o_out.ready),
        .o_cmd          (w_cmd),
        .i_sts          (w_sts)
    );

    tdpt_dp #(
        .W (VALUE_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (VALUE_WIDTH'(i_in.value)),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = w_out_valid;
    assign o_out.is_prime = w_out_is_prime;
endmodule

// ----- rtl/tdpt_checker.sv -----
// port-level assertions for the primality tester, bound to the top level
`include "trial_division_primality_test_defines.svh"

module tdpt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_is_prime
);
    `TDPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_is_prime), "stalled result changed")
    `TDPT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready,
        !i_in_ready, "second item taken while busy")
    `TDPT_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, i_in_valid && i_in_ready,
        !$rose(i_out_valid), "result appeared with no work done")
    `TDPT_ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(i_out_valid),
        !$past(i_in_ready), "result appeared while idle")
endmodule

bind trial_division_primality_test tdpt_checker u_tdpt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_is_prime (o_out.is_prime)
);

// ----- tb/tb_trial_division_primality_test.sv -----
// self-checking testbench for the trial-division primality tester
module tb_trial_division_primality_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_WIDTH    = 32;
    localparam int WATCHDOG_LIMIT = 2_000_000;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 15;

    typedef struct {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          is_prime;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    tdpt_value_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_if ();
    tdpt_result_if                              out_if ();

    trial_division_primality_test #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    t_verdict verdict_q[$];
    t_verdict head_verdict;
    int       fail_count     = 0;
    int       tx_idle_pct    = 0;
    int       rx_stall_pct   = 0;
    int       hold_off_count = 0;
    int       quiet_cycles   = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic primality_verdict(input logic [VALUE_WIDTH-1:0] v);
        longint unsigned n;
        longint unsigned d;
        if (v[VALUE_WIDTH-1])
            return 1'b0;
        n = v;
        if (n <= 1)
            return 1'b0;
        if (n <= 3)
            return 1'b1;
        if (n % 2 == 0 || n % 3 == 0)
            return 1'b0;
        for (d = 5; d * d <= n; d += 6) begin
            if (n % d == 0 || n % (d + 2) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // mostly cheap values: negatives, large multiples of small primes, small integers
    function automatic logic [VALUE_WIDTH-1:0] random_value();
        int unsigned pick;
        int unsigned factor;
        int unsigned small_primes[6] = '{2, 3, 5, 7, 11, 13};
        pick = $urandom_range(99);
        if (pick < 35)
            return $urandom() | 32'h8000_0000;
        if (pick < 55) begin
            factor = small_primes[$urandom_range(5)];
            return factor * $urandom_range(32'h7fff_ffff / factor, 2);
        end
        if (pick < 90)
            return $urandom_range(16383);
        return $urandom_range(1048575);
    endfunction

    task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
        t_verdict entry;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        entry.value    = v;
        entry.is_prime = primality_verdict(v);
        verdict_q.insert(verdict_q.size(), entry);
    endtask

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_special_values();
        logic signed [VALUE_WIDTH-1:0] special[23] = '{
            -32'sd2147483648, -32'sd1, -32'sd7, 32'sd0, 32'sd1, 32'sd2, 32'sd3,
            32'sd4, 32'sd5, 32'sd6, 32'sd7, 32'sd9, 32'sd25, 32'sd35, 32'sd49,
            32'sd121, 32'sd169, 32'sd1018081, 32'sd999983, 32'sd1000003,
            32'sd2147483646, 32'sd2147483645, 32'sd2147483647
        };
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        foreach (special[i])
            send_value(special[i]);
    endtask

    task automatic test_random_values(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (RANDOM_ITEMS)
            send_value(random_value());
    endtask

    // receiver holds off while the sender keeps offering fast items
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_off_count++;
        repeat (10)
            send_value($urandom() | 32'h8000_0000);
    endtask

    task automatic test_sender_pause();
        tx_idle_pct  = 0;
        rx_stall_pct = 15;
        repeat (4)
            send_value($urandom_range(500));
        wait_for_results();
        repeat (4)
            send_value($urandom_range(500));
    endtask

    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_count != hold_seen) begin
                hold_seen = hold_off_count;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result item: is_prime actual %0b", out_if.is_prime);
                fail_count++;
            end else begin
                head_verdict = verdict_q.pop_front();
                if (out_if.is_prime !== head_verdict.is_prime) begin
                    $error("is_prime for value %0d: expected %0b, actual %0b",
                           head_verdict.value, head_verdict.is_prime, out_if.is_prime);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.value <= '0;
        repeat (10)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_values();
        test_random_values(0, 0);
        test_random_values(83, 0);
        test_random_values(0, 83);
        test_random_values(15, 15);
        test_output_backpressure();
        test_sender_pause();

        wait_for_results();
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);
        if (fail_count == 0 && verdict_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
